// ===== rtl/core/pmd_pkg.sv =====
// shared types and constants for the mouse packet event decoder
`timescale 1ns / 1ps

package pmd_pkg;

    localparam logic [7:0] SYNC_BIT    = 8'h08;
    localparam logic [2:0] BUTTON_BITS = 3'h7;
    localparam int         QUEUE_DEPTH = 2;

    typedef enum logic [1:0]
    {
        KIND_RELEASE = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_MOTION  = 2'd2
    } event_kind_t;

    typedef struct packed
    {
        logic [2:0]  buttons;
        logic [2:0]  changed;
        logic        motion;
        logic [7:0]  dx;
        logic [7:0]  dy;
        logic [31:0] time_ms;
    } packet_t;

endpackage

// ===== rtl/core/pmd_front.sv =====
// byte assembly and packet classification
`timescale 1ns / 1ps

module pmd_front
    import pmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [31:0] timestamp_ms,
    input  logic        q_full,
    output logic        q_push,
    output packet_t     q_push_data
);

    typedef enum logic [1:0]
    {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [2:0] prior_reg, prior_next;
    logic       accept;
    logic [2:0] buttons;
    logic [2:0] changed;
    logic       motion;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign buttons  = first_reg[2:0] & BUTTON_BITS;
    assign changed  = (buttons ^ prior_reg) & BUTTON_BITS;
    assign motion   = (second_reg != 8'd0) || (data_byte != 8'd0);

    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        prior_next  = prior_reg;
        q_push      = 1'b0;
        q_push_data.buttons = buttons;
        q_push_data.changed = changed;
        q_push_data.motion  = motion;
        q_push_data.dx      = second_reg;
        q_push_data.dy      = data_byte;
        q_push_data.time_ms = timestamp_ms;
        if (accept)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    if ((data_byte & SYNC_BIT) != 8'd0)
                    begin
                        first_next = data_byte;
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    second_next = data_byte;
                    phase_next  = PH_THIRD;
                end
                default:
                begin
                    phase_next = PH_FIRST;
                    prior_next = buttons;
                    q_push     = (changed != 3'd0) || motion;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
            prior_reg  <= 3'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            prior_reg  <= prior_next;
        end
    end

endmodule

// ===== rtl/core/pmd_queue.sv =====
// short packet queue between front and back
`timescale 1ns / 1ps

module pmd_queue
    import pmd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  packet_t push_data,
    output logic    full,
    input  logic    pop,
    output packet_t pop_data,
    output logic    empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    packet_t        slots [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/pmd_back.sv =====
// event expansion and output register
`timescale 1ns / 1ps

module pmd_back
    import pmd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  packet_t           q_pop_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        event_kind,
    output logic [2:0]        button_mask,
    output logic signed [7:0] delta_x,
    output logic signed [7:0] delta_y,
    output logic [31:0]       event_time_ms,
    output logic              last_of_run
);

    packet_t     rec_reg, rec_next;
    logic        busy_reg, busy_next;
    logic [3:0]  pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg;
    logic [2:0]  mask_reg;
    logic [7:0]  dx_reg;
    logic [7:0]  dy_reg;
    logic [31:0] time_reg;
    logic        last_reg;
    logic        ready_out;
    logic        adv;
    logic [3:0]  sel;
    logic [3:0]  pend_left;
    logic        finishing;
    event_kind_t kind_sel;

    assign ready_out = !out_valid_reg || !out_stall;
    assign adv       = busy_reg && ready_out;

    // lowest pending first: left, right, middle, then motion
    always_comb
    begin
        if (pend_reg[0])
        begin
            sel = 4'b0001;
        end
        else if (pend_reg[1])
        begin
            sel = 4'b0010;
        end
        else if (pend_reg[2])
        begin
            sel = 4'b0100;
        end
        else
        begin
            sel = 4'b1000;
        end
    end

    assign pend_left = pend_reg & ~sel;
    assign finishing = adv && (pend_left == 4'd0);
    assign q_pop     = !q_empty && (!busy_reg || finishing);

    always_comb
    begin
        if (sel[3])
        begin
            kind_sel = KIND_MOTION;
        end
        else if ((rec_reg.buttons & sel[2:0]) != 3'd0)
        begin
            kind_sel = KIND_PRESS;
        end
        else
        begin
            kind_sel = KIND_RELEASE;
        end
    end

    always_comb
    begin
        rec_next  = rec_reg;
        busy_next = busy_reg;
        pend_next = pend_reg;
        if (adv)
        begin
            pend_next = pend_left;
        end
        if (finishing)
        begin
            busy_next = 1'b0;
        end
        if (q_pop)
        begin
            rec_next  = q_pop_data;
            busy_next = 1'b1;
            pend_next = {q_pop_data.motion, q_pop_data.changed};
        end
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (ready_out)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (adv)
        begin
            kind_reg <= kind_sel;
            mask_reg <= sel[3] ? 3'd0 : sel[2:0];
            dx_reg   <= sel[3] ? rec_reg.dx : 8'd0;
            dy_reg   <= sel[3] ? rec_reg.dy : 8'd0;
            time_reg <= rec_reg.time_ms;
            last_reg <= (pend_left == 4'd0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = kind_reg;
    assign button_mask   = mask_reg;
    assign delta_x       = signed'(dx_reg);
    assign delta_y       = signed'(dy_reg);
    assign event_time_ms = time_reg;
    assign last_of_run   = last_reg;

endmodule

// ===== rtl/core/ps2_mouse_packet_event_decoder.sv =====
// top level of the mouse packet event decoder
// a packet's first event goes from the queue through the record register to the output register
// throughput: one byte per cycle in and one event per cycle out while not stalled; a packet gives up to four events
// input stalls only while the packet queue between the byte front end and event back end is full
// reset: asynchronous, clears byte phase, stored bytes, button state, queue and output valid
`timescale 1ns / 1ps

module ps2_mouse_packet_event_decoder
    import pmd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic [31:0]       timestamp_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        event_kind,
    output logic [2:0]        button_mask,
    output logic signed [7:0] delta_x,
    output logic signed [7:0] delta_y,
    output logic [31:0]       event_time_ms,
    output logic              last_of_run
);

    packet_t push_data;
    packet_t pop_data;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;

    pmd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .timestamp_ms (timestamp_ms),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_data  (push_data)
    );

    pmd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    pmd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop_data    (pop_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .button_mask   (button_mask),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .event_time_ms (event_time_ms),
        .last_of_run   (last_of_run)
    );

endmodule
